[rtl/core/fmm_pkg.sv]
package fmm_pkg;

   // Matrix bounds
   localparam int MAX_INNER   = 16;
   localparam int MAX_COLS    = 16;
   localparam int STORE_DEPTH = MAX_INNER * MAX_COLS;
   localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int KIDX_W      = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
   localparam int NIDX_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int KLEN_W      = $clog2(MAX_INNER + 1);
   localparam int NLEN_W      = $clog2(MAX_COLS + 1);
   localparam int RFILL_W     = $clog2(STORE_DEPTH + 1);

   // Port field widths
   localparam int CFG_W  = 5;
   localparam int CSR_IW = 1;
   localparam int COL_W  = 4;

   // Request kinds and register indexes
   localparam logic REQ_RIGHT = 1'b0;
   localparam logic REQ_LEFT  = 1'b1;
   localparam logic [CSR_IW-1:0] CSR_INNER = 1'b0;
   localparam logic [CSR_IW-1:0] CSR_COLS  = 1'b1;

   // Unpacked float: value = sig / 2^SIG_LEAD * 2^(exp - 127)
   localparam int SIG_W     = 50;
   localparam int SIG_LEAD  = 48;
   localparam int SIG_LSB   = 25;
   localparam int SIG_GUARD = 24;
   localparam int EXP_W     = 11;
   localparam int LZ_W      = 6;
   localparam int EXP_BIAS  = 127;

   localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
   localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;

   typedef struct packed {
      logic                    spec;
      logic [31:0]             spec_bits;
      logic                    sign;
      logic signed [EXP_W-1:0] exp;
      logic [SIG_W-1:0]        sig;
   } fp_pre_type;

   typedef struct packed {
      logic                b_we;
      logic [STORE_AW-1:0] b_waddr;
      logic                a_we;
      logic [KIDX_W-1:0]   a_waddr;
      logic                b_re;
      logic [STORE_AW-1:0] b_raddr;
      logic [KIDX_W-1:0]   a_raddr;
      logic                do_mul;
      logic                do_align;
      logic                do_norm;
      logic                do_round;
      logic                round_to_sum;
      logic                clr_sum;
      logic                load_out;
   } dp_cmd_type;

endpackage

[rtl/core/fmm_ram.sv]
module fmm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/fmm_round.sv]
module fmm_round (
   input  logic               clock,
   input  logic               norm_en,
   input  fmm_pkg::fp_pre_type pre,
   output logic [31:0]        result
);

   localparam int EW = fmm_pkg::EXP_W + 2;
   localparam logic signed [EW-1:0] EXP_TOP = EW'(254);

   fmm_pkg::fp_pre_type norm_ff;
   logic [fmm_pkg::LZ_W-1:0] lz_ff;
   logic [fmm_pkg::LZ_W-1:0] lz_in;

   logic signed [EW-1:0] lim;
   logic signed [EW-1:0] lzm1;
   logic signed [EW-1:0] shl;
   logic signed [EW-1:0] neg;
   logic signed [EW-1:0] e_res;
   logic [5:0] rsh;
   logic [fmm_pkg::SIG_W+63:0] ext;
   logic [fmm_pkg::SIG_W-1:0]  shifted;
   logic sticky;
   logic guard;
   logic inc;
   logic ovf;
   logic [7:0]  exf;
   logic [30:0] base;
   logic [30:0] rounded;

   // leading zero count, highest set bit wins
   always_comb begin
      lz_in = fmm_pkg::LZ_W'(fmm_pkg::SIG_W);
      for (int i = 0; i < fmm_pkg::SIG_W; i++) begin
         if (pre.sig[i]) begin
            lz_in = fmm_pkg::LZ_W'(fmm_pkg::SIG_W - 1 - i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (norm_en) begin
         norm_ff <= pre;
         lz_ff   <= lz_in;
      end
   end

   // normalize, clamp at the subnormal floor, round to nearest even
   always_comb begin
      lim   = EW'(norm_ff.exp) - EW'(1);
      lim   = {{2{norm_ff.exp[fmm_pkg::EXP_W-1]}}, norm_ff.exp} - EW'(1);
      lzm1  = EW'(lz_ff) - EW'(1);
      shl   = (lzm1 < lim) ? lzm1 : lim;
      neg   = -shl;
      rsh   = 6'd0;
      ext   = '0;
      if (shl >= 0) begin
         shifted = norm_ff.sig << shl[5:0];
         sticky  = 1'b0;
      end else begin
         rsh     = (neg > EW'(63)) ? 6'd63 : neg[5:0];
         ext     = {norm_ff.sig, 64'd0} >> rsh;
         shifted = ext[fmm_pkg::SIG_W+63:64];
         sticky  = |ext[63:0];
      end
      e_res  = {{2{norm_ff.exp[fmm_pkg::EXP_W-1]}}, norm_ff.exp} - shl;
      guard  = shifted[fmm_pkg::SIG_GUARD];
      sticky = sticky | (|shifted[fmm_pkg::SIG_GUARD-1:0]);
      exf    = shifted[fmm_pkg::SIG_LEAD] ? e_res[7:0] : 8'd0;
      ovf    = shifted[fmm_pkg::SIG_LEAD] && (e_res > EXP_TOP);
      base   = {exf, shifted[fmm_pkg::SIG_LEAD-1:fmm_pkg::SIG_LSB]};
      inc    = guard & (sticky | shifted[fmm_pkg::SIG_LSB]);
      rounded = base + 31'(inc);
      if (norm_ff.spec) begin
         result = norm_ff.spec_bits;
      end else if (norm_ff.sig == '0) begin
         result = {norm_ff.sign, 31'd0};
      end else if (ovf) begin
         result = {norm_ff.sign, 8'hFF, 23'd0};
      end else begin
         result = {norm_ff.sign, rounded};
      end
   end

endmodule

[rtl/core/fmm_datapath.sv]
module fmm_datapath (
   input  logic               clock,
   input  fmm_pkg::dp_cmd_type cmd,
   input  logic [31:0]        wdata,
   output logic [31:0]        result_bits
);

   logic [31:0] left_row_ff [fmm_pkg::MAX_INNER];
   logic [31:0] a_op_ff;
   logic [31:0] b_rdata;
   logic [31:0] prod_ff;
   logic [31:0] sum_ff;
   logic [31:0] out_ff;
   logic [31:0] rnd_result;
   fmm_pkg::fp_pre_type pre_ff;
   fmm_pkg::fp_pre_type mul_pre;
   fmm_pkg::fp_pre_type add_pre;

   fmm_ram #(.WIDTH(32), .DEPTH(fmm_pkg::STORE_DEPTH)) u_right_store (
      .clock (clock),
      .we    (cmd.b_we),
      .waddr (cmd.b_waddr),
      .wdata (wdata),
      .re    (cmd.b_re),
      .raddr (cmd.b_raddr),
      .rdata (b_rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.a_we) begin
         left_row_ff[cmd.a_waddr] <= wdata;
      end
      if (cmd.b_re) begin
         a_op_ff <= left_row_ff[cmd.a_raddr];
      end
   end

   // product stage
   logic [7:0]  ma_e, mb_e, ea, eb;
   logic [23:0] ma, mb;
   logic [47:0] prod;
   logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, m_sign;

   always_comb begin
      ma_e   = a_op_ff[30:23];
      mb_e   = b_rdata[30:23];
      a_nan  = (&ma_e) && (|a_op_ff[22:0]);
      b_nan  = (&mb_e) && (|b_rdata[22:0]);
      a_inf  = (&ma_e) && !(|a_op_ff[22:0]);
      b_inf  = (&mb_e) && !(|b_rdata[22:0]);
      a_zero = ~|a_op_ff[30:0];
      b_zero = ~|b_rdata[30:0];
      ma     = {|ma_e, a_op_ff[22:0]};
      mb     = {|mb_e, b_rdata[22:0]};
      ea     = (|ma_e) ? ma_e : 8'd1;
      eb     = (|mb_e) ? mb_e : 8'd1;
      prod   = ma * mb;
      m_sign = a_op_ff[31] ^ b_rdata[31];
      mul_pre.sign = m_sign;
      mul_pre.exp  = fmm_pkg::EXP_W'(ea) + fmm_pkg::EXP_W'(eb)
                   - fmm_pkg::EXP_W'(fmm_pkg::EXP_BIAS);
      mul_pre.sig  = {prod, 2'b00};
      mul_pre.spec = 1'b1;
      if (a_nan) begin
         mul_pre.spec_bits = a_op_ff | fmm_pkg::QUIET_BIT;
      end else if (b_nan) begin
         mul_pre.spec_bits = b_rdata | fmm_pkg::QUIET_BIT;
      end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
         mul_pre.spec_bits = fmm_pkg::DEFAULT_NAN;
      end else if (a_inf || b_inf) begin
         mul_pre.spec_bits = {m_sign, 8'hFF, 23'd0};
      end else begin
         mul_pre.spec      = 1'b0;
         mul_pre.spec_bits = '0;
      end
   end

   // alignment and add stage: sum_ff + prod_ff
   logic [7:0]  xe, ye, eb_big, es_small, dexp;
   logic [5:0]  dcl;
   logic [23:0] mx, my, mbig, msmall;
   logic [fmm_pkg::SIG_W-1:0]    big_sig, full_s, small_sig, add_sig;
   logic [fmm_pkg::SIG_W+63:0]   aext;
   logic x_nan, y_nan, x_inf, y_inf, x_big, s_big;

   always_comb begin
      xe     = sum_ff[30:23];
      ye     = prod_ff[30:23];
      x_nan  = (&xe) && (|sum_ff[22:0]);
      y_nan  = (&ye) && (|prod_ff[22:0]);
      x_inf  = (&xe) && !(|sum_ff[22:0]);
      y_inf  = (&ye) && !(|prod_ff[22:0]);
      mx     = {|xe, sum_ff[22:0]};
      my     = {|ye, prod_ff[22:0]};
      x_big  = sum_ff[30:0] >= prod_ff[30:0];
      mbig   = x_big ? mx : my;
      msmall = x_big ? my : mx;
      eb_big   = x_big ? ((|xe) ? xe : 8'd1) : ((|ye) ? ye : 8'd1);
      es_small = x_big ? ((|ye) ? ye : 8'd1) : ((|xe) ? xe : 8'd1);
      s_big  = x_big ? sum_ff[31] : prod_ff[31];
      dexp   = eb_big - es_small;
      dcl    = (dexp > 8'd63) ? 6'd63 : dexp[5:0];
      big_sig = {1'b0, mbig, 25'd0};
      full_s  = {1'b0, msmall, 25'd0};
      aext    = {full_s, 64'd0} >> dcl;
      small_sig = aext[fmm_pkg::SIG_W+63:64] | fmm_pkg::SIG_W'(|aext[63:0]);
      add_sig = (sum_ff[31] == prod_ff[31]) ? (big_sig + small_sig) : (big_sig - small_sig);
      add_pre.sig  = add_sig;
      add_pre.exp  = fmm_pkg::EXP_W'(eb_big);
      add_pre.sign = (add_sig == '0) ? (sum_ff[31] & prod_ff[31]) : s_big;
      add_pre.spec = 1'b1;
      if (x_nan) begin
         add_pre.spec_bits = sum_ff | fmm_pkg::QUIET_BIT;
      end else if (y_nan) begin
         add_pre.spec_bits = prod_ff | fmm_pkg::QUIET_BIT;
      end else if (x_inf && y_inf && (sum_ff[31] != prod_ff[31])) begin
         add_pre.spec_bits = fmm_pkg::DEFAULT_NAN;
      end else if (x_inf) begin
         add_pre.spec_bits = sum_ff;
      end else if (y_inf) begin
         add_pre.spec_bits = prod_ff;
      end else begin
         add_pre.spec      = 1'b0;
         add_pre.spec_bits = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_mul) begin
         pre_ff <= mul_pre;
      end else if (cmd.do_align) begin
         pre_ff <= add_pre;
      end
      if (cmd.do_round && !cmd.round_to_sum) begin
         prod_ff <= rnd_result;
      end
      if (cmd.clr_sum) begin
         sum_ff <= '0;
      end else if (cmd.do_round && cmd.round_to_sum) begin
         sum_ff <= rnd_result;
      end
      if (cmd.load_out) begin
         out_ff <= sum_ff;
      end
   end

   fmm_round u_round (
      .clock   (clock),
      .norm_en (cmd.do_norm),
      .pre     (pre_ff),
      .result  (rnd_result)
   );

   assign result_bits = out_ff;

endmodule

[rtl/core/fmm_ctrl.sv]
module fmm_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_type,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [fmm_pkg::COL_W-1:0]    rsp_column,
   output logic                         rsp_last_in_row,
   input  logic                         csr_write_enable,
   input  logic [fmm_pkg::CSR_IW-1:0]   csr_index,
   input  logic [fmm_pkg::CFG_W-1:0]    csr_write_data,
   output fmm_pkg::dp_cmd_type          cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_READ  = 4'd1;
   localparam logic [3:0] S_MUL   = 4'd2;
   localparam logic [3:0] S_MNORM = 4'd3;
   localparam logic [3:0] S_MRND  = 4'd4;
   localparam logic [3:0] S_ALIGN = 4'd5;
   localparam logic [3:0] S_ANORM = 4'd6;
   localparam logic [3:0] S_ARND  = 4'd7;
   localparam logic [3:0] S_EMIT  = 4'd8;

   localparam int KLW = fmm_pkg::KLEN_W;
   localparam int NLW = fmm_pkg::NLEN_W;
   localparam int RFW = fmm_pkg::RFILL_W;
   localparam int SAW = fmm_pkg::STORE_AW;

   logic [3:0] state_ff, state_in;
   logic [fmm_pkg::KIDX_W-1:0] k_ff, k_in;
   logic [fmm_pkg::NIDX_W-1:0] n_ff, n_in;
   logic [SAW-1:0] b_addr_ff, b_addr_in;
   logic [RFW-1:0] rfill_ff, rfill_in, rpos;
   logic [KLW-1:0] lfill_ff, lfill_in, lpos;
   logic [fmm_pkg::CFG_W-1:0] inner_ff, inner_in, cols_ff, cols_in;
   logic rsp_valid_ff, rsp_valid_in, last_ff, last_in;
   logic [fmm_pkg::COL_W-1:0] col_ff, col_in;
   logic [KLW-1:0] k_len;
   logic [NLW-1:0] n_len;
   logic [RFW-1:0] kn;
   logic accept, k_last, n_last, out_free;

   function automatic logic [KLW-1:0] clamp_k(input logic [fmm_pkg::CFG_W-1:0] v);
      logic [KLW-1:0] r;
      if (v == '0) begin
         r = KLW'(1);
      end else if (int'(v) > fmm_pkg::MAX_INNER) begin
         r = KLW'(fmm_pkg::MAX_INNER);
      end else begin
         r = KLW'(v);
      end
      return r;
   endfunction

   function automatic logic [NLW-1:0] clamp_n(input logic [fmm_pkg::CFG_W-1:0] v);
      logic [NLW-1:0] r;
      if (v == '0) begin
         r = NLW'(1);
      end else if (int'(v) > fmm_pkg::MAX_COLS) begin
         r = NLW'(fmm_pkg::MAX_COLS);
      end else begin
         r = NLW'(v);
      end
      return r;
   endfunction

   always_comb begin
      k_len    = clamp_k(inner_ff);
      n_len    = clamp_n(cols_ff);
      kn       = RFW'(k_len) * RFW'(n_len);
      req_ready = (state_ff == S_IDLE);
      accept   = req_valid && req_ready;
      k_last   = (KLW'(k_ff) == k_len - KLW'(1));
      n_last   = (NLW'(n_ff) == n_len - NLW'(1));
      out_free = !rsp_valid_ff || rsp_ready;
      rpos     = (rfill_ff >= kn) ? '0 : rfill_ff;
      lpos     = (lfill_ff >= k_len) ? '0 : lfill_ff;

      state_in  = state_ff;
      k_in      = k_ff;
      n_in      = n_ff;
      b_addr_in = b_addr_ff;
      rfill_in  = rfill_ff;
      lfill_in  = lfill_ff;
      inner_in  = inner_ff;
      cols_in   = cols_ff;
      col_in    = col_ff;
      last_in   = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd = '0;
      cmd.b_waddr = rpos[SAW-1:0];
      cmd.a_waddr = lpos[fmm_pkg::KIDX_W-1:0];
      cmd.b_raddr = b_addr_ff;
      cmd.a_raddr = k_ff;

      if (csr_write_enable) begin
         if (csr_index == fmm_pkg::CSR_INNER) begin
            inner_in = csr_write_data;
         end
         if (csr_index == fmm_pkg::CSR_COLS) begin
            cols_in = csr_write_data;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept && (req_type == fmm_pkg::REQ_RIGHT)) begin
               cmd.b_we = 1'b1;
               rfill_in = rpos + RFW'(1);
            end else if (accept) begin
               cmd.a_we = 1'b1;
               if (lpos + KLW'(1) == k_len) begin
                  // row complete: start column zero
                  lfill_in    = '0;
                  k_in        = '0;
                  n_in        = '0;
                  b_addr_in   = '0;
                  cmd.clr_sum = 1'b1;
                  state_in    = S_READ;
               end else begin
                  lfill_in = lpos + KLW'(1);
               end
            end
         end
         S_READ: begin
            cmd.b_re = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.do_mul = 1'b1;
            state_in   = S_MNORM;
         end
         S_MNORM: begin
            cmd.do_norm = 1'b1;
            state_in    = S_MRND;
         end
         S_MRND: begin
            cmd.do_round = 1'b1;
            state_in     = S_ALIGN;
         end
         S_ALIGN: begin
            cmd.do_align = 1'b1;
            state_in     = S_ANORM;
         end
         S_ANORM: begin
            cmd.do_norm = 1'b1;
            state_in    = S_ARND;
         end
         S_ARND: begin
            cmd.do_round     = 1'b1;
            cmd.round_to_sum = 1'b1;
            if (k_last) begin
               state_in = S_EMIT;
            end else begin
               k_in      = k_ff + fmm_pkg::KIDX_W'(1);
               b_addr_in = b_addr_ff + SAW'(n_len);
               state_in  = S_READ;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               col_in       = fmm_pkg::COL_W'(n_ff);
               last_in      = n_last;
               if (n_last) begin
                  state_in = S_IDLE;
               end else begin
                  n_in        = n_ff + fmm_pkg::NIDX_W'(1);
                  k_in        = '0;
                  b_addr_in   = SAW'(n_ff) + SAW'(1);
                  cmd.clr_sum = 1'b1;
                  state_in    = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         k_ff         <= '0;
         n_ff         <= '0;
         b_addr_ff    <= '0;
         rfill_ff     <= '0;
         lfill_ff     <= '0;
         inner_ff     <= fmm_pkg::CFG_W'(16);
         cols_ff      <= fmm_pkg::CFG_W'(16);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         n_ff         <= n_in;
         b_addr_ff    <= b_addr_in;
         rfill_ff     <= rfill_in;
         lfill_ff     <= lfill_in;
         inner_ff     <= inner_in;
         cols_ff      <= cols_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff  <= col_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_column      = col_ff;
   assign rsp_last_in_row = last_ff;

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_k_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (KLW'(k_ff) < k_len))
      else $error("inner index beyond row length");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      rfill_ff <= RFW'(fmm_pkg::STORE_DEPTH))
      else $error("right fill position beyond store");

   a_row_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ARND) && k_last |=> (state_ff == S_EMIT))
      else $error("finished sum not emitted");

endmodule

[rtl/core/float_matrix_multiply_unit.sv]
// Single-precision matrix multiply C = A x B, one result row per A row.
// Request channel (req_valid/req_ready): req_type low writes the next B
// element in row-major order, req_type high writes the next element of the
// current A row; req_value_bits carries raw IEEE single bits.
// Response channel (rsp_valid/rsp_ready): N results per finished A row,
// column ascending, rsp_last_in_row on column N-1.
// Config port: csr_write_enable with csr_index 0 (K) or 1 (N); write only
// while the block is idle. Values are clamped to 1..16.
// Operation: the block stays ready after a B element or a non-final A
// element. The last A element of a row starts N columns of K multiply-add
// steps. Each step reads the operands, multiplies, normalizes and rounds
// the product, then aligns and adds it to the sum and normalizes and rounds
// again, through one multiplier, one adder aligner and one shared
// normalize/round unit. The request side stays closed while a row computes.
// A stalled receiver holds the result in the output register and the
// sequencer waits before overwriting it; no result is dropped.
// Reset clears fill positions and returns K and N to 16; the B store
// holds old data until rewritten.
module float_matrix_multiply_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_type,
   input  logic [31:0]                req_value_bits,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [31:0]                rsp_result_bits,
   output logic [fmm_pkg::COL_W-1:0]  rsp_column,
   output logic                       rsp_last_in_row,
   input  logic                       csr_write_enable,
   input  logic [fmm_pkg::CSR_IW-1:0] csr_index,
   input  logic [fmm_pkg::CFG_W-1:0]  csr_write_data
);

   // command bundle from sequencer to datapath
   fmm_pkg::dp_cmd_type cmd;

   fmm_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_column       (rsp_column),
      .rsp_last_in_row  (rsp_last_in_row),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd)
   );

   // stores, multiplier, adder and rounding live here
   fmm_datapath u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .wdata       (req_value_bits),
      .result_bits (rsp_result_bits)
   );

endmodule
